@@ rtl/core/sews_pkg.sv @@
package sews_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd3;

    // Register widths and reset values
    localparam int TAP_CNT_W = 7;
    localparam int RATIO_W   = 16;
    localparam int GAIN_W    = 20;

    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 7'd1;
    localparam logic [RATIO_W-1:0]   RATIO_RST   = 16'd0;
    localparam logic [GAIN_W-1:0]    GAIN_RST    = 20'd524288;

    // Tap weight: Q1.16, first tap is exactly one
    localparam int              COEF_W   = 17;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;
    localparam int              COEF_FRAC = 16;

    // Normalization: the sum is split in 16-bit chunks, each multiplied by the gain
    localparam int CHUNK_W    = 16;
    localparam int NORM_SHIFT = 36;

    // Result field width
    localparam int OUT_W = 32;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP_RD,
        ST_TAP_MA,
        ST_TAP_MB,
        ST_TAP_MC,
        ST_TAP_NX,
        ST_NRM_M,
        ST_NRM_A,
        ST_SAT,
        ST_OUT
    } state_t;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MS_SAMPLE,
        MS_RATIO,
        MS_CHUNK
    } mul_sel_t;

    // Control from the sequencer to the sample window
    typedef struct packed {
        logic push;
        logic clear;
        logic rd_valid;
    } win_ctrl_t;

endpackage

@@ rtl/core/sews_window.sv @@
module sews_window #(
    parameter int MAX_TAPS    = sews_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = sews_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sews_pkg::win_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0]          wr_data,
    input  logic [$clog2(MAX_TAPS+1):0]     rd_dist,
    output logic [SAMPLE_BITS-1:0]          rd_data,
    output logic                            rd_ok,
    output logic [$clog2(2*MAX_TAPS)-1:0]   fill
);
    import sews_pkg::*;

    localparam int DEPTH = 2 * MAX_TAPS - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int DW    = KW + 1;
    localparam int CNTW  = $clog2(2 * MAX_TAPS);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          wp_next;
    logic [CNTW-1:0]        fill_reg;
    logic [CNTW-1:0]        fill_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_ok_reg;
    logic                   dist_ok;
    logic [DW:0]            addr_sum;
    logic [DW:0]            addr_wrap;
    logic [AW-1:0]          rd_addr;

    // Distances at or beyond the fill count are flagged invalid by rd_ok
    assign dist_ok = ctrl.rd_valid && (rd_dist < DW'(fill_reg));

    // Distance back from the newest sample to a circular address
    always_comb
    begin
        addr_sum  = (DW+1)'(wp_reg) + (DW+1)'(DEPTH - 1) - (DW+1)'(rd_dist);
        addr_wrap = (addr_sum >= (DW+1)'(DEPTH)) ? (addr_sum - (DW+1)'(DEPTH)) : addr_sum;
        rd_addr   = dist_ok ? AW'(addr_wrap) : '0;
    end

    // Write pointer and fill count
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (fill_reg != CNTW'(DEPTH))
            begin
                fill_next = fill_reg + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            rd_ok_reg <= dist_ok;
        end
    end

    // Sample memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wp_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign rd_ok   = rd_ok_reg;
    assign fill    = fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNTW'(DEPTH))
        else $error("window fill count beyond depth");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= AW'(DEPTH - 1))
        else $error("window write pointer beyond depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (fill_reg == '0))
        else $error("window not empty after clear");

endmodule

@@ rtl/core/symmetric_exp_window_smoother.sv @@
// Disabled: a sample's value goes through res_reg and the output state into the output register;
// no new sample is taken until it is loaded. Enabled: each result is computed on the single
// shared multiplier, 4 steps per tap and 2 per normalization chunk (NCH = 4 at 32-bit samples).
// An enabled sample that makes no result is only written to the window; a last sample flushes
// min(count, K) results back to back. The output register frees the input side.
// Reset: registers to defaults, window empty by fill count, no clearing pass needed.
module symmetric_exp_window_smoother #(
    parameter int MAX_TAPS    = sews_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = sews_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sews_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sews_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       sample,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sews_pkg::OUT_W-1:0]        smoothed,
    output logic                              last_res
);
    import sews_pkg::*;

    localparam int DEPTH  = 2 * MAX_TAPS - 1;
    localparam int KW     = $clog2(MAX_TAPS + 1);
    localparam int DW     = KW + 1;
    localparam int CNTW   = $clog2(2 * MAX_TAPS);
    localparam int ACC_W  = CHUNK_W * ((SAMPLE_BITS + 24 + CHUNK_W - 1) / CHUNK_W);
    localparam int NCH    = ACC_W / CHUNK_W;
    localparam int NCW    = $clog2(NCH);
    localparam int MAW    = GAIN_W + 1;
    localparam int MB     = ((SAMPLE_BITS > RATIO_W) ? SAMPLE_BITS : RATIO_W) + 1;
    localparam int PW     = MAW + MB;
    localparam int TW     = ACC_W + MAW;
    localparam int QTW    = TW - NORM_SHIFT - SAMPLE_BITS + 1;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration registers
    logic                 enable_reg;
    logic [TAP_CNT_W-1:0] tap_count_reg;
    logic [RATIO_W-1:0]   decay_ratio_reg;
    logic [GAIN_W-1:0]    norm_gain_reg;

    // Control state
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Datapath registers
    logic [KW-1:0]            d_reg;
    logic [KW-1:0]            j_reg;
    logic [NCW-1:0]           ch_reg;
    logic                     flush_reg;
    logic [COEF_W-1:0]        c_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [TW-1:0]     nrm_reg;
    logic [OUT_W-1:0]         res_reg;
    logic                     res_last_reg;
    logic [OUT_W-1:0]         smoothed_reg;
    logic                     last_res_reg;

    // Sequencer outputs
    win_ctrl_t        win_ctrl;
    logic [DW-1:0]    rd_dist;
    mul_sel_t         mul_sel;
    logic             ld_out;

    // Window interface
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   rd_ok;
    logic [CNTW-1:0]        fill;

    // Derived values
    logic                     in_fire;
    logic [KW-1:0]            k_eff;
    logic [CNTW-1:0]          cnt_inc;
    logic [DW-1:0]            pend;
    logic [KW-1:0]            d_init;
    logic                     start_calc;
    logic                     j_last;
    logic                     ch_last;
    logic                     more_flush;
    logic signed [MAW-1:0]    mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [CHUNK_W-1:0]       chunk;
    logic [QTW-1:0]           q_top;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic [OUT_W-1:0]         pass_val;

    sews_window #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .wr_data (sample[SAMPLE_BITS-1:0]),
        .rd_dist (rd_dist),
        .rd_data (rd_data),
        .rd_ok   (rd_ok),
        .fill    (fill)
    );

    // Effective tap count: zero acts as one, clipped to MAX_TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (tap_count_reg > TAP_CNT_W'(MAX_TAPS))
        begin
            k_eff = KW'(MAX_TAPS);
        end
        else
        begin
            k_eff = KW'(tap_count_reg);
        end
    end

    // Start-of-result decisions taken at the input transaction
    always_comb
    begin
        in_fire    = in_valid && in_ready;
        cnt_inc    = (fill == CNTW'(DEPTH)) ? fill : fill + CNTW'(1);
        pend       = (DW'(cnt_inc) < DW'(k_eff)) ? DW'(cnt_inc) : DW'(k_eff);
        d_init     = last ? KW'(pend - DW'(1)) : k_eff - KW'(1);
        start_calc = enable_reg && (last || (DW'(cnt_inc) >= DW'(k_eff)));
        j_last     = ((j_reg + KW'(1)) == k_eff);
        ch_last    = (ch_reg == NCW'(NCH - 1));
        more_flush = flush_reg && (d_reg != '0);
    end

    // Shared multiplier
    always_comb
    begin
        chunk = acc_reg[ACC_W-1 -: CHUNK_W];
        mul_a = $signed({{(MAW-COEF_W){1'b0}}, c_reg});
        mul_b = rd_ok ? MB'($signed(rd_data)) : '0;
        case (mul_sel)
            MS_SAMPLE:
            begin
                mul_a = $signed({{(MAW-COEF_W){1'b0}}, c_reg});
                mul_b = rd_ok ? MB'($signed(rd_data)) : '0;
            end
            MS_RATIO:
            begin
                mul_a = $signed({{(MAW-COEF_W){1'b0}}, c_reg});
                mul_b = $signed({{(MB-RATIO_W){1'b0}}, decay_ratio_reg});
            end
            MS_CHUNK:
            begin
                mul_a = $signed({1'b0, norm_gain_reg});
                // top chunk carries the sign, the rest are unsigned digits
                mul_b = (ch_reg == '0) ? MB'($signed(chunk))
                                       : $signed({{(MB-CHUNK_W){1'b0}}, chunk});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        acc_sum = acc_reg + ACC_W'(prod_reg);
    end

    // Saturate floor(sum * gain / 2^36) to the sample range
    always_comb
    begin
        q_top = nrm_reg[TW-1 : NORM_SHIFT+SAMPLE_BITS-1];
        if ((&q_top) || (~|q_top))
        begin
            sat_val = $signed(nrm_reg[NORM_SHIFT+SAMPLE_BITS-1 : NORM_SHIFT]);
        end
        else if (nrm_reg[TW-1])
        begin
            sat_val = SAT_MIN;
        end
        else
        begin
            sat_val = SAT_MAX;
        end
        pass_val = OUT_W'($signed(sample[SAMPLE_BITS-1:0]));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!enable_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (start_calc)
                    begin
                        state_next = ST_TAP_RD;
                    end
                end
            end
            ST_TAP_RD: state_next = ST_TAP_MA;
            ST_TAP_MA: state_next = ST_TAP_MB;
            ST_TAP_MB: state_next = ST_TAP_MC;
            ST_TAP_MC: state_next = ST_TAP_NX;
            ST_TAP_NX: state_next = j_last ? ST_NRM_M : ST_TAP_MA;
            ST_NRM_M:  state_next = ST_NRM_A;
            ST_NRM_A:  state_next = ch_last ? ST_SAT : ST_NRM_M;
            ST_SAT:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (ld_out)
                begin
                    state_next = more_flush ? ST_TAP_RD : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready          = 1'b0;
        win_ctrl.push     = 1'b0;
        win_ctrl.clear    = 1'b0;
        win_ctrl.rd_valid = 1'b0;
        rd_dist           = '0;
        mul_sel           = MS_SAMPLE;
        ld_out            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                win_ctrl.push  = in_fire && enable_reg;
                win_ctrl.clear = in_fire && !enable_reg;
            end
            ST_TAP_RD:
            begin
                // older side of tap j
                win_ctrl.rd_valid = 1'b1;
                rd_dist           = DW'(d_reg) + DW'(j_reg);
            end
            ST_TAP_MA:
            begin
                // newer side of tap j, absent at the center and past the buffer start
                win_ctrl.rd_valid = (j_reg != '0) && (d_reg >= j_reg);
                rd_dist           = DW'(d_reg) - DW'(j_reg);
                mul_sel           = MS_SAMPLE;
            end
            ST_TAP_MB:
            begin
                mul_sel = MS_SAMPLE;
            end
            ST_TAP_MC:
            begin
                mul_sel = MS_RATIO;
            end
            ST_TAP_NX:
            begin
                // older side of the next tap
                win_ctrl.rd_valid = !j_last;
                rd_dist           = DW'(d_reg) + DW'(j_reg) + DW'(1);
            end
            ST_NRM_M:
            begin
                mul_sel = MS_CHUNK;
            end
            ST_OUT:
            begin
                ld_out         = !out_valid_reg || out_ready;
                win_ctrl.clear = ld_out && flush_reg && (d_reg == '0);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            enable_reg      <= 1'b0;
            tap_count_reg   <= TAP_CNT_RST;
            decay_ratio_reg <= RATIO_RST;
            norm_gain_reg   <= GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ENABLE:    enable_reg      <= cfg_data[0];
                    CFG_TAP_COUNT: tap_count_reg   <= cfg_data[TAP_CNT_W-1:0];
                    CFG_DECAY:     decay_ratio_reg <= cfg_data[RATIO_W-1:0];
                    CFG_GAIN:      norm_gain_reg   <= cfg_data[GAIN_W-1:0];
                    default:       enable_reg      <= enable_reg;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!enable_reg)
                    begin
                        res_reg      <= pass_val;
                        res_last_reg <= last;
                        flush_reg    <= 1'b0;
                        d_reg        <= '0;
                    end
                    else
                    begin
                        flush_reg <= last;
                        d_reg     <= d_init;
                        j_reg     <= '0;
                        c_reg     <= COEF_ONE;
                        acc_reg   <= '0;
                    end
                end
            end
            ST_TAP_MA:
            begin
                prod_reg <= mul_p;
            end
            ST_TAP_MB, ST_TAP_MC:
            begin
                acc_reg  <= acc_sum;
                prod_reg <= mul_p;
            end
            ST_TAP_NX:
            begin
                // next weight: floor(c * ratio / 2^16)
                c_reg   <= prod_reg[COEF_FRAC +: COEF_W];
                j_reg   <= j_reg + KW'(1);
                nrm_reg <= '0;
                ch_reg  <= '0;
            end
            ST_NRM_M:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg << CHUNK_W;
            end
            ST_NRM_A:
            begin
                nrm_reg <= (nrm_reg <<< CHUNK_W) + TW'(prod_reg);
                ch_reg  <= ch_reg + NCW'(1);
            end
            ST_SAT:
            begin
                res_reg      <= OUT_W'(sat_val);
                res_last_reg <= flush_reg && (d_reg == '0);
            end
            ST_OUT:
            begin
                if (ld_out && more_flush)
                begin
                    d_reg   <= d_reg - KW'(1);
                    j_reg   <= '0;
                    c_reg   <= COEF_ONE;
                    acc_reg <= '0;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (ld_out)
        begin
            smoothed_reg <= res_reg;
            last_res_reg <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;
    assign last_res  = last_res_reg;

    a_coef_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP_MA) |-> (c_reg <= COEF_ONE))
        else $error("tap weight above one");

    a_center_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP_RD) |-> (d_reg < k_eff))
        else $error("center outside the tap span");

    a_pass_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !enable_reg) |=> (state_reg == ST_OUT))
        else $error("pass-through transaction without result");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result presented outside output state");

endmodule
